[sv/page_framebuffer_line_draw_macros.svh]
// assertion macros used by the frame store top level
`ifndef PAGE_FRAMEBUFFER_LINE_DRAW_MACROS_SVH
`define PAGE_FRAMEBUFFER_LINE_DRAW_MACROS_SVH

// checked outside reset only
`define PFLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PFLD_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pfld_pkg.sv]
// shared constants, types and helper functions of the page frame store
`default_nettype none

package pfld_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT + 1);
  localparam int CLIP_W        = 18;

  localparam logic [1:0] INK_BLACK  = 2'd0;
  localparam logic [1:0] INK_WHITE  = 2'd1;
  localparam logic [1:0] INK_INVERT = 2'd2;

  typedef enum logic [1:0] {
    REQ_HLINE,
    REQ_VLINE,
    REQ_CLEAR,
    REQ_READ
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_RDWAIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [COL_W-1:0]  col_first;
    logic [COL_W-1:0]  col_last;
    logic [PAGE_W-1:0] page_first;
    logic [PAGE_W-1:0] page_last;
    logic [ROW_W-1:0]  row_lo;
    logic [ROW_W-1:0]  row_hi;
  } line_t;

  function automatic logic [ADDR_W-1:0] store_addr(logic [PAGE_W-1:0] page,
                                                    logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(col);
  endfunction

  // bits of one page byte whose rows fall in lo .. hi-1
  function automatic logic [7:0] row_mask(logic [PAGE_W-1:0] page,
                                          logic [ROW_W-1:0] lo,
                                          logic [ROW_W-1:0] hi);
    logic [7:0]  mask;
    logic [15:0] row;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      row = 16'(16'(page) * 16'd8) + 16'(b);
      mask[b] = (row >= 16'(lo)) && (row < 16'(hi));
    end
    return mask;
  endfunction

  function automatic logic [7:0] paint(logic [7:0] data, logic [7:0] mask,
                                       logic [1:0] code);
    logic [7:0] res;
    case (code)
      INK_WHITE:  res = data | mask;
      INK_BLACK:  res = data & ~mask;
      INK_INVERT: res = data ^ mask;
      default:    res = data;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/pfld_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module pfld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/pfld_clip.sv]
// clips a request to the screen and gives its column, page and row ranges
`default_nettype none

module pfld_clip (
  input  wire pfld_pkg::req_t        req_type,
  input  wire logic signed [15:0]    pos_x,
  input  wire logic signed [15:0]    pos_y,
  input  wire logic signed [15:0]    span,
  output pfld_pkg::line_t            line
);

  localparam logic signed [pfld_pkg::CLIP_W-1:0] W_S =
    pfld_pkg::CLIP_W'(pfld_pkg::SCREEN_WIDTH);
  localparam logic signed [pfld_pkg::CLIP_W-1:0] H_S =
    pfld_pkg::CLIP_W'(pfld_pkg::SCREEN_HEIGHT);
  localparam logic signed [pfld_pkg::CLIP_W-1:0] ZERO_S = '0;
  localparam logic signed [pfld_pkg::CLIP_W-1:0] ONE_S  = pfld_pkg::CLIP_W'(1);

  logic signed [pfld_pkg::CLIP_W-1:0] xe, ye, we;
  logic signed [pfld_pkg::CLIP_W-1:0] xend, yend;
  logic signed [pfld_pkg::CLIP_W-1:0] cs, ce, rs, re;
  logic signed [pfld_pkg::CLIP_W-1:0] ce_m1, re_m1, ye_p1;
  logic x_on, y_on;

  assign xe = pfld_pkg::CLIP_W'(pos_x);
  assign ye = pfld_pkg::CLIP_W'(pos_y);
  assign we = pfld_pkg::CLIP_W'(span);

  assign xend = xe + we;
  assign yend = ye + we;

  assign x_on = (xe >= ZERO_S) && (xe < W_S);
  assign y_on = (ye >= ZERO_S) && (ye < H_S);

  assign cs = (xe < ZERO_S) ? ZERO_S : xe;
  assign ce = (xend > W_S) ? W_S : xend;
  assign rs = (ye < ZERO_S) ? ZERO_S : ye;
  assign re = (yend > H_S) ? H_S : yend;

  assign ce_m1 = ce - ONE_S;
  assign re_m1 = re - ONE_S;
  assign ye_p1 = ye + ONE_S;

  always_comb begin
    line = '0;
    case (req_type)
      pfld_pkg::REQ_HLINE: begin
        line.hit        = y_on && (ce > cs);
        line.col_first  = cs[pfld_pkg::COL_W-1:0];
        line.col_last   = ce_m1[pfld_pkg::COL_W-1:0];
        line.page_first = ye[pfld_pkg::PAGE_W+2:3];
        line.page_last  = ye[pfld_pkg::PAGE_W+2:3];
        line.row_lo     = ye[pfld_pkg::ROW_W-1:0];
        line.row_hi     = ye_p1[pfld_pkg::ROW_W-1:0];
      end
      pfld_pkg::REQ_VLINE: begin
        line.hit        = x_on && (re > rs);
        line.col_first  = xe[pfld_pkg::COL_W-1:0];
        line.col_last   = xe[pfld_pkg::COL_W-1:0];
        line.page_first = rs[pfld_pkg::PAGE_W+2:3];
        line.page_last  = re_m1[pfld_pkg::PAGE_W+2:3];
        line.row_lo     = rs[pfld_pkg::ROW_W-1:0];
        line.row_hi     = re[pfld_pkg::ROW_W-1:0];
      end
      pfld_pkg::REQ_READ: begin
        line.hit        = x_on && y_on;
        line.col_first  = xe[pfld_pkg::COL_W-1:0];
        line.col_last   = xe[pfld_pkg::COL_W-1:0];
        line.page_first = ye[pfld_pkg::PAGE_W+2:3];
        line.page_last  = ye[pfld_pkg::PAGE_W+2:3];
      end
      default: begin
        line = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/page_framebuffer_line_draw.sv]
// top level of the page frame store with line fill, clear and byte read
// flow: a read goes SETUP, RDWAIT, RESP; a line SETUP, RUN, DRAIN, RESP; a clear SETUP, CLEAR, RESP
// throughput: one request at a time; a line streams one byte per cycle through
// the read-modify-write loop on the store ram (read port and write port each cycle)
// reset: control clears at once, then a zeroing sweep of all 1024 store bytes with in_stall high
`default_nettype none

module page_framebuffer_line_draw (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] span,
  input  wire logic [1:0]         ink,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              read_data
);

  `include "page_framebuffer_line_draw_macros.svh"

  localparam logic [pfld_pkg::ADDR_W-1:0] CLR_LAST =
    pfld_pkg::ADDR_W'(pfld_pkg::STORE_BYTES - 1);

  pfld_pkg::state_t state, state_next;
  pfld_pkg::req_t   req_q;
  pfld_pkg::line_t  line;

  logic signed [15:0] x_q, y_q, span_q;
  logic [1:0]         ink_q;

  logic [pfld_pkg::COL_W-1:0]  col;
  logic [pfld_pkg::PAGE_W-1:0] page;
  logic                        pend;
  logic [pfld_pkg::ADDR_W-1:0] pend_addr;
  logic [7:0]                  pend_mask;
  logic [7:0]                  resp_data;
  logic [pfld_pkg::ADDR_W-1:0] clr_addr;
  logic                        clr_resp;

  logic [pfld_pkg::ADDR_W-1:0] cur_addr;
  logic [7:0]                  cur_mask;
  logic                        at_last;
  logic                        out_free;
  logic                        clr_last;

  logic                        ram_wr_en;
  logic [pfld_pkg::ADDR_W-1:0] ram_wr_addr;
  logic [7:0]                  ram_wr_data;
  logic                        ram_rd_en;
  logic [pfld_pkg::ADDR_W-1:0] ram_rd_addr;
  logic [7:0]                  ram_rd_data;

  pfld_clip u_clip (
    .req_type (req_q),
    .pos_x    (x_q),
    .pos_y    (y_q),
    .span     (span_q),
    .line     (line)
  );

  pfld_ram #(
    .WIDTH (8),
    .DEPTH (pfld_pkg::STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cur_addr = pfld_pkg::store_addr(page, col);
  assign cur_mask = pfld_pkg::row_mask(page, line.row_lo, line.row_hi);
  assign at_last  = (col == line.col_last) && (page == line.page_last);
  assign out_free = !out_valid || !out_stall;
  assign clr_last = (clr_addr == CLR_LAST);

  always_comb begin
    state_next = state;
    case (state)
      pfld_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = clr_resp ? pfld_pkg::ST_RESP : pfld_pkg::ST_IDLE;
        end
      end
      pfld_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pfld_pkg::ST_SETUP;
        end
      end
      pfld_pkg::ST_SETUP: begin
        case (req_q)
          pfld_pkg::REQ_HLINE,
          pfld_pkg::REQ_VLINE: state_next = line.hit ? pfld_pkg::ST_RUN : pfld_pkg::ST_RESP;
          pfld_pkg::REQ_CLEAR: state_next = pfld_pkg::ST_CLEAR;
          pfld_pkg::REQ_READ:  state_next = line.hit ? pfld_pkg::ST_RDWAIT : pfld_pkg::ST_RESP;
          default:             state_next = pfld_pkg::ST_RESP;
        endcase
      end
      pfld_pkg::ST_RUN: begin
        if (at_last) begin
          state_next = pfld_pkg::ST_DRAIN;
        end
      end
      pfld_pkg::ST_DRAIN:  state_next = pfld_pkg::ST_RESP;
      pfld_pkg::ST_RDWAIT: state_next = pfld_pkg::ST_RESP;
      pfld_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = pfld_pkg::ST_IDLE;
        end
      end
      default: state_next = pfld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != pfld_pkg::ST_IDLE);
    ram_rd_en   = 1'b0;
    ram_rd_addr = cur_addr;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_addr;
    ram_wr_data = pfld_pkg::paint(ram_rd_data, pend_mask, ink_q);
    case (state)
      pfld_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      pfld_pkg::ST_SETUP: begin
        ram_rd_en   = (req_q == pfld_pkg::REQ_READ) && line.hit;
        ram_rd_addr = pfld_pkg::store_addr(line.page_first, line.col_first);
      end
      pfld_pkg::ST_RUN: begin
        ram_rd_en = 1'b1;
        ram_wr_en = pend;
      end
      pfld_pkg::ST_DRAIN: begin
        ram_wr_en = pend;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfld_pkg::ST_CLEAR;
      clr_addr  <= '0;
      clr_resp  <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == pfld_pkg::ST_RUN);
      if (state == pfld_pkg::ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
      if (state == pfld_pkg::ST_SETUP) begin
        clr_resp <= (req_q == pfld_pkg::REQ_CLEAR);
      end
      if (state == pfld_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pfld_pkg::ST_IDLE && in_valid) begin
      req_q  <= pfld_pkg::req_t'(req_type);
      x_q    <= pos_x;
      y_q    <= pos_y;
      span_q <= span;
      ink_q  <= ink;
    end
    if (state == pfld_pkg::ST_SETUP) begin
      col       <= line.col_first;
      page      <= line.page_first;
      resp_data <= '0;
    end
    if (state == pfld_pkg::ST_RUN) begin
      pend_addr <= cur_addr;
      pend_mask <= cur_mask;
      if (!at_last) begin
        if (col != line.col_last) begin
          col <= col + 1'b1;
        end else begin
          page <= page + 1'b1;
        end
      end
    end
    if (state == pfld_pkg::ST_RDWAIT) begin
      resp_data <= ram_rd_data;
    end
    if (state == pfld_pkg::ST_RESP && out_free) begin
      read_data <= resp_data;
    end
  end

  `PFLD_ASSERT_ALL(a_rst_sweep, rst |=> (state == pfld_pkg::ST_CLEAR), "reset must start the zeroing sweep")
  `PFLD_ASSERT(a_no_rmw_overlap, (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr), "read and write hit the same byte")
  `PFLD_ASSERT(a_sweep_whole, (state == pfld_pkg::ST_CLEAR && !clr_last) |=> (state == pfld_pkg::ST_CLEAR), "zeroing sweep left early")
  `PFLD_ASSERT(a_pend_in_loop, pend |-> (state == pfld_pkg::ST_RUN || state == pfld_pkg::ST_DRAIN), "pending write outside the fill loop")
  `PFLD_ASSERT(a_beat_from_resp, $rose(out_valid) |-> ($past(state) == pfld_pkg::ST_RESP), "result beat without a finished request")

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for the page frame store: line draw, clear and byte read checked against a shadow image
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] INK_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 437;

  typedef struct {
    pfld_pkg::req_t     kind;
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic signed [15:0] len;
    logic [1:0]         color;
  } draw_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] span = '0;
  logic [1:0]         ink = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         read_data;

  draw_req_t  pending_reqs[$];
  logic [7:0] expected_bytes[$];
  logic [7:0] shadow_image[pfld_pkg::STORE_BYTES];
  draw_req_t  next_req;
  logic       in_taken = 1'b0;
  int issued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_reads = 0;
  int n_lines = 0;
  int n_clears = 0;
  int n_results = 0;

  page_framebuffer_line_draw uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .span(span), .ink(ink),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data)
  );

  always #2 clk = ~clk;

  task automatic ink_byte(input int idx, input logic [7:0] m, input logic [1:0] color);
    if (idx >= 0 && idx < pfld_pkg::STORE_BYTES) begin
      case (color)
        pfld_pkg::INK_WHITE:  shadow_image[idx] = shadow_image[idx] | m;
        pfld_pkg::INK_BLACK:  shadow_image[idx] = shadow_image[idx] & ~m;
        pfld_pkg::INK_INVERT: shadow_image[idx] = shadow_image[idx] ^ m;
        default:    ;
      endcase
    end
  endtask

  // updates the shadow image and returns the byte the block should answer with
  task automatic frame_apply(input draw_req_t r, output logic [7:0] answer);
    int x, y, w, i, pg, lo, hi, end_row, b;
    logic [7:0] m;
    answer = '0;
    x = r.col;
    y = r.row;
    w = r.len;
    case (r.kind)
      pfld_pkg::REQ_HLINE: begin
        if (y >= 0 && y < pfld_pkg::SCREEN_HEIGHT) begin
          if (x < 0) begin
            w = w + x;
            x = 0;
          end
          if (x + w > pfld_pkg::SCREEN_WIDTH) w = pfld_pkg::SCREEN_WIDTH - x;
          m = 8'b1 << (y % 8);
          for (i = 0; i < w; i++)
            ink_byte((y / 8) * pfld_pkg::SCREEN_WIDTH + x + i, m, r.color);
        end
      end
      pfld_pkg::REQ_VLINE: begin
        if (x >= 0 && x < pfld_pkg::SCREEN_WIDTH) begin
          if (y < 0) begin
            w = w + y;
            y = 0;
          end
          if (y + w > pfld_pkg::SCREEN_HEIGHT) w = pfld_pkg::SCREEN_HEIGHT - y;
          if (w > 0) begin
            end_row = y + w;
            for (pg = y / 8; pg * 8 < end_row; pg++) begin
              lo = (pg * 8 < y) ? y : pg * 8;
              hi = (pg * 8 + 8 > end_row) ? end_row : pg * 8 + 8;
              m = '0;
              for (b = 0; b < 8; b++) m[b] = (pg * 8 + b >= lo) && (pg * 8 + b < hi);
              ink_byte(pg * pfld_pkg::SCREEN_WIDTH + x, m, r.color);
            end
          end
        end
      end
      pfld_pkg::REQ_CLEAR: begin
        for (i = 0; i < pfld_pkg::STORE_BYTES; i++) shadow_image[i] = '0;
      end
      default: begin
        if (x >= 0 && x < pfld_pkg::SCREEN_WIDTH && y >= 0 && y < pfld_pkg::SCREEN_HEIGHT)
          answer = shadow_image[(y / 8) * pfld_pkg::SCREEN_WIDTH + x];
      end
    endcase
  endtask

  task automatic enqueue(input pfld_pkg::req_t kind, input int x, input int y,
                         input int len, input logic [1:0] color);
    draw_req_t r;
    r.kind = kind;
    r.col = 16'(x);
    r.row = 16'(y);
    r.len = 16'(len);
    r.color = color;
    pending_reqs.push_back(r);
    issued_count++;
  endtask

  function automatic draw_req_t random_request();
    draw_req_t r;
    int sel;
    sel = $urandom_range(999);
    r.color = ($urandom_range(19) == 0) ? INK_NONE : 2'($urandom_range(2));
    if (sel < 15) begin
      r.kind = pfld_pkg::REQ_CLEAR;
      r.col = 16'($urandom);
      r.row = 16'($urandom);
      r.len = 16'($urandom);
    end else if (sel < 80) begin
      // noise over the whole field ranges
      r.kind = pfld_pkg::req_t'($urandom_range(3));
      r.col = 16'($urandom);
      r.row = 16'($urandom);
      r.len = 16'($urandom);
      r.color = 2'($urandom_range(3));
    end else if (sel < 400) begin
      r.kind = pfld_pkg::REQ_READ;
      r.col = 16'(int'($urandom_range(135)) - 4);
      r.row = 16'(int'($urandom_range(71)) - 4);
      r.len = 16'($urandom);
    end else if (sel < 700) begin
      r.kind = pfld_pkg::REQ_HLINE;
      r.col = 16'(int'($urandom_range(167)) - 20);
      r.row = 16'(int'($urandom_range(69)) - 3);
      sel = $urandom_range(9);
      if (sel < 6) r.len = 16'(int'($urandom_range(26)) - 2);
      else if (sel < 9) r.len = 16'($urandom_range(140));
      else r.len = 16'($urandom);
    end else begin
      r.kind = pfld_pkg::REQ_VLINE;
      r.col = 16'(int'($urandom_range(131)) - 2);
      r.row = 16'(int'($urandom_range(83)) - 10);
      sel = $urandom_range(9);
      if (sel < 8) r.len = 16'(int'($urandom_range(33)) - 3);
      else if (sel < 9) r.len = 16'($urandom_range(90));
      else r.len = 16'($urandom);
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= next_req.kind;
        pos_x <= next_req.col;
        pos_y <= next_req.row;
        span <= next_req.len;
        ink <= next_req.color;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [7:0] answer;
    logic [7:0] want;
    draw_req_t  got_req;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        got_req.kind = pfld_pkg::req_t'(req_type);
        got_req.col = pos_x;
        got_req.row = pos_y;
        got_req.len = span;
        got_req.color = ink;
        frame_apply(got_req, answer);
        expected_bytes.push_back(answer);
        accepted_count++;
        case (got_req.kind)
          pfld_pkg::REQ_READ:  n_reads++;
          pfld_pkg::REQ_CLEAR: n_clears++;
          default:   n_lines++;
        endcase
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d with nothing expected, read_data %02h", n_results,
                     read_data);
        end else begin
          want = expected_bytes.pop_front();
          if (read_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result beat %0d: read_data expected %02h got %02h", n_results, want,
                       read_data);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("page_framebuffer_line_draw test failed");
      $finish;
    end
  end

  task automatic drain();
    while (accepted_count != issued_count || expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int phase, n, base;
    for (n = 0; n < pfld_pkg::STORE_BYTES; n++) shadow_image[n] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed corners
    enqueue(pfld_pkg::REQ_HLINE, 0, 0, pfld_pkg::SCREEN_WIDTH, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_READ, 0, 0, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, pfld_pkg::SCREEN_WIDTH - 1, 7, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_HLINE, -10, pfld_pkg::SCREEN_HEIGHT - 1, 20, pfld_pkg::INK_INVERT);
    enqueue(pfld_pkg::REQ_HLINE, 120, 0, 100, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_HLINE, 5, -1, 10, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_HLINE, 5, pfld_pkg::SCREEN_HEIGHT, 10, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_HLINE, 5, 9, 0, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_HLINE, 5, 9, -5, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_HLINE, -32768, 10, 32767, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_HLINE, 32767, 10, -32768, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_VLINE, 3, -4, 70, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_VLINE, pfld_pkg::SCREEN_WIDTH, 0, 10, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_VLINE, -1, 0, 10, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_VLINE, 4, 2, 20, INK_NONE);
    enqueue(pfld_pkg::REQ_HLINE, 0, 3, 50, INK_NONE);
    enqueue(pfld_pkg::REQ_VLINE, 3, 5, 3, pfld_pkg::INK_INVERT);
    enqueue(pfld_pkg::REQ_VLINE, pfld_pkg::SCREEN_WIDTH - 1, 60, 32767, pfld_pkg::INK_WHITE);
    enqueue(pfld_pkg::REQ_READ, 3, 0, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, pfld_pkg::SCREEN_WIDTH - 1, pfld_pkg::SCREEN_HEIGHT - 1, 0,
            pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, -1, 0, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, 0, pfld_pkg::SCREEN_HEIGHT, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, -32768, 32767, -1, INK_NONE);
    enqueue(pfld_pkg::REQ_CLEAR, 0, 0, 0, pfld_pkg::INK_BLACK);
    enqueue(pfld_pkg::REQ_READ, 3, 16, 0, pfld_pkg::INK_BLACK);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      base = accepted_count;
      for (n = 0; n < ITEMS_PER_PHASE; n++) pending_reqs.push_back(random_request());
      issued_count += ITEMS_PER_PHASE;
      if (phase == 0 || phase == 3) begin
        while (accepted_count < base + 100) @(posedge clk);
        hold_asked++;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d requests: %0d line draws, %0d reads, %0d clears, %0d result beats",
             accepted_count, n_lines, n_reads, n_clears, n_results);
    $display("idle/stall mixes 0/0, 49/0, 0/49, 9/9 with two long output hold-offs");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("page_framebuffer_line_draw test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_bytes.size());
      $display("page_framebuffer_line_draw test failed");
    end
    $finish;
  end

endmodule
